// ===== sv/ccfr_pkg.sv =====
// ----------------------------------------------------------------------------
// ccfr_pkg
// Shared types, codes and helpers for the crc checked frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package ccfr_pkg;

  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [7:0]  MAX_DATA_BYTES    = 8'd252;
  localparam logic [7:0]  LAST_INDEX_IDLE   = 8'hFF;
  // id, length and the two crc bytes frame the data; the last crc byte sits at index length + 3
  localparam logic [7:0]  FRAME_OVERHEAD    = 8'd3;
  localparam logic [15:0] CRC_POLY_RESET    = 16'hA001;
  localparam logic [15:0] GAP_TIMEOUT_RESET = 16'd3000;

  typedef enum logic [2:0] {
    EV_STORED  = 3'd0,
    EV_GOOD    = 3'd1,
    EV_CRC_ERR = 3'd2,
    EV_TIMEOUT = 3'd3,
    EV_LEN_ERR = 3'd4
  } ev_kind_t;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_CRC_POLYNOMIAL    = 1'b0,
    REG_GAP_TIMEOUT_TICKS = 1'b1
  } cfg_reg_t;

  // one byte through a reflected crc16, lsb first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                           input logic [7:0]  data,
                                           input logic [15:0] poly);
    logic [15:0] crc;
    crc = crc_in;
    for (int k = 0; k < 8; k++) begin
      if (crc[0] ^ data[k]) begin
        crc = (crc >> 1) ^ poly;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ccfr_in_if.sv =====
// ----------------------------------------------------------------------------
// ccfr_in_if
// Input channel: received link bytes and timer ticks.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccfr_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== sv/ccfr_out_if.sv =====
// ----------------------------------------------------------------------------
// ccfr_out_if
// Output channel: one event word per received byte or frame abort.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccfr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [7:0] byte_value;
  logic [7:0] byte_position;
  logic [7:0] frame_id;
  logic [7:0] frame_length;
  logic       frame_end;

  modport source (output valid, output event_kind, output byte_value,
                  output byte_position, output frame_id, output frame_length,
                  output frame_end, input ready);
  modport sink   (input valid, input event_kind, input byte_value,
                  input byte_position, input frame_id, input frame_length,
                  input frame_end, output ready);
endinterface

`default_nettype wire

// ===== sv/crc_checked_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// crc_checked_frame_receiver
// Parses id / length / data / crc16 frames from a byte stream, with gap timeout.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  in_ch     in   valid / ready    command, rx_byte
//  out_ch    out  valid / ready    event_kind, byte_value, byte_position,
//                                  frame_id, frame_length, frame_end
//  apb       in   psel / penable   paddr, pwdata, prdata (pready tied high)
//
//  one word per cycle while in_ch.ready is high; results are registered
//  the per-cycle path is one 8-bit crc step plus the frame position compares
//  in_ch.ready is low only while the output register holds a word not taken
//  rst is synchronous, active high; all but out_* payload regs get reset values
// ----------------------------------------------------------------------------
`default_nettype none

module crc_checked_frame_receiver (
  input  wire logic                           clk,
  input  wire logic                           rst,
  ccfr_in_if.sink                             in_ch,
  ccfr_out_if.source                          out_ch,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ccfr_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [ccfr_pkg::PDATA_W-1:0]   pwdata,
  output logic      [ccfr_pkg::PDATA_W-1:0]   prdata,
  output logic                                pready
);
  import ccfr_pkg::*;

  // configuration
  logic [15:0] crc_polynomial;
  logic [15:0] gap_timeout_ticks;
  cfg_reg_t    reg_sel;
  logic        cfg_write;

  // frame state
  logic [7:0]  byte_index,    byte_index_next;
  logic [7:0]  last_index,    last_index_next;
  logic [15:0] running_crc,   running_crc_next;
  logic [7:0]  crc_high_byte, crc_high_byte_next;
  logic [7:0]  held_id,       held_id_next;
  logic [7:0]  held_length,   held_length_next;
  logic [15:0] gap_counter,   gap_counter_next;
  logic        gap_armed,     gap_armed_next;

  // result of the current word
  logic        res_valid;
  ev_kind_t    res_kind;
  logic [7:0]  res_value;
  logic [7:0]  res_position;
  logic [7:0]  res_id;
  logic [7:0]  res_length;
  logic        res_end;

  // output register
  logic        out_valid;
  ev_kind_t    out_kind;
  logic [7:0]  out_value;
  logic [7:0]  out_position;
  logic [7:0]  out_id;
  logic [7:0]  out_length;
  logic        out_end;

  logic        in_fire;
  logic        stored;
  logic [15:0] gap_limit;
  logic [15:0] gap_inc;
  logic [7:0]  pos;
  logic [7:0]  b;

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign reg_sel   = cfg_reg_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_polynomial    <= CRC_POLY_RESET;
      gap_timeout_ticks <= GAP_TIMEOUT_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_CRC_POLYNOMIAL:    crc_polynomial    <= pwdata[15:0];
        REG_GAP_TIMEOUT_TICKS: gap_timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CRC_POLYNOMIAL:    prdata = {16'h0000, crc_polynomial};
      REG_GAP_TIMEOUT_TICKS: prdata = {16'h0000, gap_timeout_ticks};
      default:               prdata = '0;
    endcase
  end

  // ---------------- frame parsing ----------------
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign pos         = byte_index;
  assign b           = in_ch.rx_byte;
  // a zero timeout behaves as one tick
  assign gap_limit   = (gap_timeout_ticks == 16'd0) ? 16'd1 : gap_timeout_ticks;
  assign gap_inc     = gap_counter + 16'd1;

  always_comb begin
    byte_index_next    = byte_index;
    last_index_next    = last_index;
    running_crc_next   = running_crc;
    crc_high_byte_next = crc_high_byte;
    held_id_next       = held_id;
    held_length_next   = held_length;
    gap_counter_next   = gap_counter;
    gap_armed_next     = gap_armed;
    res_valid          = 1'b0;
    res_kind           = EV_STORED;
    res_value          = b;
    res_position       = pos;
    res_id             = held_id;
    res_length         = held_length;
    res_end            = 1'b0;
    stored             = 1'b0;

    if (in_fire) begin
      if (cmd_t'(in_ch.command) == CMD_TICK) begin
        if (gap_armed) begin
          gap_counter_next = gap_inc;
          if (gap_inc >= gap_limit) begin
            res_valid        = 1'b1;
            res_kind         = EV_TIMEOUT;
            res_value        = 8'd0;
            res_end          = 1'b1;
            byte_index_next  = 8'd0;
            gap_armed_next   = 1'b0;
            gap_counter_next = 16'd0;
          end
        end
      end else begin
        stored = 1'b1;
        if (pos == 8'd0) begin
          held_id_next       = b;
          held_length_next   = 8'd0;
          last_index_next    = LAST_INDEX_IDLE;
          running_crc_next   = crc_feed(16'h0000, b, crc_polynomial);
          crc_high_byte_next = 8'd0;
          res_id             = b;
          res_length         = 8'd0;
        end else if (pos == 8'd1) begin
          if (b > MAX_DATA_BYTES) begin
            stored     = 1'b0;
            res_valid  = 1'b1;
            res_kind   = EV_LEN_ERR;
            res_length = 8'd0;
            res_end    = 1'b1;
            byte_index_next  = 8'd0;
            gap_armed_next   = 1'b0;
            gap_counter_next = 16'd0;
          end else begin
            held_length_next = b;
            last_index_next  = b + FRAME_OVERHEAD;
            running_crc_next = crc_feed(running_crc, b, crc_polynomial);
            res_length       = b;
          end
        end else if (pos == last_index) begin
          stored    = 1'b0;
          res_valid = 1'b1;
          res_kind  = ({crc_high_byte, b} == running_crc) ? EV_GOOD : EV_CRC_ERR;
          res_end   = 1'b1;
          byte_index_next  = 8'd0;
          gap_armed_next   = 1'b0;
          gap_counter_next = 16'd0;
        end else if (pos + 8'd1 == last_index) begin
          crc_high_byte_next = b;
        end else begin
          running_crc_next = crc_feed(running_crc, b, crc_polynomial);
        end

        if (stored) begin
          res_valid        = 1'b1;
          byte_index_next  = pos + 8'd1;
          gap_counter_next = 16'd0;
          gap_armed_next   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= 8'd0;
      last_index    <= LAST_INDEX_IDLE;
      running_crc   <= 16'h0000;
      crc_high_byte <= 8'd0;
      held_id       <= 8'd0;
      held_length   <= 8'd0;
      gap_counter   <= 16'd0;
      gap_armed     <= 1'b0;
    end else begin
      byte_index    <= byte_index_next;
      last_index    <= last_index_next;
      running_crc   <= running_crc_next;
      crc_high_byte <= crc_high_byte_next;
      held_id       <= held_id_next;
      held_length   <= held_length_next;
      gap_counter   <= gap_counter_next;
      gap_armed     <= gap_armed_next;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= res_valid;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_kind     <= res_kind;
      out_value    <= res_value;
      out_position <= res_position;
      out_id       <= res_id;
      out_length   <= res_length;
      out_end      <= res_end;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.event_kind    = out_kind;
  assign out_ch.byte_value    = out_value;
  assign out_ch.byte_position = out_position;
  assign out_ch.frame_id      = out_id;
  assign out_ch.frame_length  = out_length;
  assign out_ch.frame_end     = out_end;

`ifndef SYNTHESIS
  // closing or aborting a frame leaves the receiver waiting for an id byte
  a_end_to_idle: assert property (@(posedge clk) disable iff (rst)
    (in_fire && res_valid && res_end) |=> (byte_index == 8'd0 && !gap_armed))
    else $error("frame end did not return to idle");

  // the gap timer only runs once a byte of the frame is in
  a_armed_mid_frame: assert property (@(posedge clk) disable iff (rst)
    gap_armed |-> (byte_index != 8'd0))
    else $error("gap timer armed with no partial frame");

  // only a byte-stored word leaves the frame open
  a_kind_vs_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_kind == EV_STORED) == !out_end))
    else $error("event kind disagrees with frame end");

  // past the length byte the held length is always in range
  a_length_range: assert property (@(posedge clk) disable iff (rst)
    (byte_index > 8'd1) |-> (held_length <= MAX_DATA_BYTES))
    else $error("held length out of range");

  // a new word appears only from an accepted input
  a_rise_from_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_fire))
    else $error("output word without accepted input");
`endif

endmodule

`default_nettype wire
